[design/tga_rle_pkg.sv]
// Shared types, register indexes and pixel helpers for the TGA RLE pixel decoder.
`timescale 1ns / 1ps
`default_nettype none

package tga_rle_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RLE_ENABLED = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIFTEEN_BIT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ONE   = 4'd3;

  localparam logic [2:0] PIX_BYTES_MIN   = 3'd2;
  localparam logic [2:0] PIX_BYTES_MAX   = 3'd4;
  localparam logic [2:0] PIX_BYTES_RESET = 3'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [2:0] out_count;
    logic [7:0] copies;
  } out_item_t;

  // Widen a 5-bit component sitting in bits 7:3 to a full 8-bit value.
  function automatic logic [7:0] widen5(input logic [4:0] c);
    logic [7:0] v;
    v = {c, 3'b000};
    return v + {5'd0, v[7:5]};
  endfunction

endpackage

`default_nettype wire

[design/tga_rle_pixel_decoder_top.sv]
// Top level of the TGA RLE pixel decoder: packet tracking, pixel gather and conversion.
`timescale 1ns / 1ps
`default_nettype none

// TGA truecolor pixel-stream decoder. Feed the image data one byte per input
// beat; each completed pixel leaves as one output beat with its converted bytes,
// the number of valid bytes and a copy count (greater than one only for the
// pixel of a run-length repeat packet). Header bytes and partial pixels give no
// output beat. The block takes one byte every cycle: packet and gather state
// update at the input handshake and the result lands in a single output
// register, so a byte is accepted whenever that register is empty or being
// drained in the same cycle; out_valid rises in the cycle after the completing
// byte is accepted. Set start_image on the first byte of an image to drop any
// packet or partial pixel left over. Write configuration (index 0 rle_enabled,
// 1 pixel_bytes, 2 fifteen_bit, 3 alpha_one) only while the block is idle;
// cfg_ready is always high and unknown indexes are ignored.
module tga_rle_pixel_decoder_top (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  tga_rle_pkg::in_item_t                 in_data,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output tga_rle_pkg::out_item_t                out_data,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [tga_rle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [tga_rle_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers
  logic       rle_en_r;
  logic [2:0] pix_bytes_r;
  logic       fifteen_r;
  logic       alpha_one_r;

  // Packet and gather state
  logic [7:0] repeat_left_r,  repeat_left_nxt;
  logic [7:0] literal_left_r, literal_left_nxt;
  logic       in_repeat_r,    in_repeat_nxt;
  logic [1:0] byte_pos_r,     byte_pos_nxt;
  logic [7:0] gather_r   [4];
  logic [7:0] gather_nxt [4];

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  tga_rle_pkg::out_item_t out_data_r,  out_data_nxt;

  // Working values
  logic                   in_fire;
  logic [7:0]             rep_v, lit_v;
  logic                   inrep_v;
  logic [1:0]             pos_v;
  logic                   header;
  logic [2:0]             pix_size;
  logic [7:0]             gview [4];
  logic                   emit;
  logic [7:0]             copies_v;
  tga_rle_pkg::out_item_t pixel;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Effective pixel size: clamp to 2..4, force 2 in 15-bit mode.
  always_comb begin
    if (fifteen_r) begin
      pix_size = tga_rle_pkg::PIX_BYTES_MIN;
    end else if (pix_bytes_r < tga_rle_pkg::PIX_BYTES_MIN) begin
      pix_size = tga_rle_pkg::PIX_BYTES_MIN;
    end else if (pix_bytes_r > tga_rle_pkg::PIX_BYTES_MAX) begin
      pix_size = tga_rle_pkg::PIX_BYTES_MAX;
    end else begin
      pix_size = pix_bytes_r;
    end
  end

  // Start flag drops packet state before the byte is looked at.
  always_comb begin
    rep_v   = in_data.start_image ? 8'd0 : repeat_left_r;
    lit_v   = in_data.start_image ? 8'd0 : literal_left_r;
    inrep_v = in_data.start_image ? 1'b0 : in_repeat_r;
    pos_v   = in_data.start_image ? 2'd0 : byte_pos_r;
    header  = rle_en_r && (lit_v == 8'd0) && !inrep_v;
  end

  // Gather bytes as they look once the current byte is written.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      gview[i] = (pos_v == 2'(i)) ? in_data.data_byte : gather_r[i];
    end
  end

  // Pixel conversion from the gathered bytes.
  always_comb begin
    pixel = '0;
    if (fifteen_r) begin
      pixel.out_byte0 = tga_rle_pkg::widen5(gview[1][6:2]);
      pixel.out_byte1 = tga_rle_pkg::widen5({gview[1][1:0], gview[0][7:5]});
      pixel.out_byte2 = tga_rle_pkg::widen5(gview[0][4:0]);
      if (alpha_one_r) begin
        // Alpha bit is inverted: set means transparent.
        pixel.out_byte3 = gview[1][7] ? 8'd0 : 8'd255;
        pixel.out_count = 3'd4;
      end else begin
        pixel.out_count = 3'd3;
      end
    end else if (pix_size == 3'd2) begin
      pixel.out_byte0 = gview[0];
      pixel.out_byte1 = gview[1];
      pixel.out_count = 3'd2;
    end else begin
      // BGR(A) to RGB(A)
      pixel.out_byte0 = gview[2];
      pixel.out_byte1 = gview[1];
      pixel.out_byte2 = gview[0];
      if (pix_size == 3'd4) begin
        pixel.out_byte3 = gview[3];
        pixel.out_count = 3'd4;
      end else begin
        pixel.out_count = 3'd3;
      end
    end
    pixel.copies = copies_v;
  end

  // Packet tracking and byte gather.
  always_comb begin
    repeat_left_nxt  = repeat_left_r;
    literal_left_nxt = literal_left_r;
    in_repeat_nxt    = in_repeat_r;
    byte_pos_nxt     = byte_pos_r;
    gather_nxt       = gather_r;
    emit             = 1'b0;
    copies_v         = 8'd1;
    if (in_fire) begin
      repeat_left_nxt  = rep_v;
      literal_left_nxt = lit_v;
      in_repeat_nxt    = inrep_v;
      byte_pos_nxt     = pos_v;
      if (header) begin
        if (in_data.data_byte[7]) begin
          in_repeat_nxt   = 1'b1;
          repeat_left_nxt = in_data.data_byte - 8'd127;
        end else begin
          literal_left_nxt = in_data.data_byte + 8'd1;
        end
        byte_pos_nxt = 2'd0;
      end else begin
        gather_nxt[pos_v] = in_data.data_byte;
        if (({1'b0, pos_v} + 3'd1) < pix_size) begin
          byte_pos_nxt = pos_v + 2'd1;
        end else begin
          byte_pos_nxt = 2'd0;
          emit         = 1'b1;
          if (rle_en_r) begin
            if (inrep_v) begin
              copies_v        = rep_v;
              repeat_left_nxt = 8'd0;
              in_repeat_nxt   = 1'b0;
            end else begin
              literal_left_nxt = lit_v - 8'd1;
            end
          end
        end
      end
    end
  end

  // Output register: load on a completed pixel, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle_en_r    <= 1'b0;
      pix_bytes_r <= tga_rle_pkg::PIX_BYTES_RESET;
      fifteen_r   <= 1'b0;
      alpha_one_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tga_rle_pkg::REG_RLE_ENABLED: rle_en_r    <= cfg_data[0];
        tga_rle_pkg::REG_PIXEL_BYTES: pix_bytes_r <= cfg_data;
        tga_rle_pkg::REG_FIFTEEN_BIT: fifteen_r   <= cfg_data[0];
        tga_rle_pkg::REG_ALPHA_ONE:   alpha_one_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_left_r  <= 8'd0;
      literal_left_r <= 8'd0;
      in_repeat_r    <= 1'b0;
      byte_pos_r     <= 2'd0;
      out_valid_r    <= 1'b0;
    end else begin
      repeat_left_r  <= repeat_left_nxt;
      literal_left_r <= literal_left_nxt;
      in_repeat_r    <= in_repeat_nxt;
      byte_pos_r     <= byte_pos_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    gather_r   <= gather_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

[design/tga_rle_checker.sv]
// Port-level checker for the TGA RLE pixel decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_ready,
  input wire                                out_valid,
  input wire                                out_ready,
  input tga_rle_pkg::out_item_t             out_data
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed or dropped while stalled");

  // Empty output register never blocks input.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // Byte count is always 2, 3 or 4.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_count == 3'd2 || out_data.out_count == 3'd3 ||
                   out_data.out_count == 3'd4))
    else $error("bad out_count");

  // Copy count is never zero.
  a_copies: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.copies != 8'd0)
    else $error("zero copy count");

  // Two-byte pixels leave the upper bytes clear.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_count == 3'd2 |->
      out_data.out_byte2 == 8'd0 && out_data.out_byte3 == 8'd0)
    else $error("unused bytes not zero");

endmodule

bind tga_rle_pixel_decoder_top tga_rle_checker u_tga_rle_checker (.*);

`default_nettype wire
